/* rtl/rtdec_pkg.sv */
// ============================================================================
// rtdec_pkg - shared types and constants for the RGB5A3 tile decoder
// Register indexes, the per-texel control word and channel widening tables.
// ============================================================================
package rtdec_pkg;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH_PX  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_PX = 2'd1;
  localparam logic [1:0] CFG_ROW_PITCH = 2'd2;

  // Register widths and reset values
  localparam int DIM_W   = 11;
  localparam int PITCH_W = 15;
  localparam int TEXEL_W = 16;
  localparam int OFFS_W  = 24;
  localparam int ARGB_W  = 32;

  localparam logic [DIM_W-1:0]   WIDTH_RST  = 11'd4;
  localparam logic [DIM_W-1:0]   HEIGHT_RST = 11'd4;
  localparam logic [PITCH_W-1:0] PITCH_RST  = 15'd16;

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  // Classification made by the front end for every texel
  typedef struct packed {
    logic last;    // final texel of the image
    logic opaque;  // bit 15 set: 5/5/5 color, alpha forced to full
  } rtdec_ctl_t;

  // floor(v * 255 / 7)
  function automatic logic [7:0] widen3(input logic [2:0] v);
    logic [7:0] res;
    case (v)
      3'd0:    res = 8'd0;
      3'd1:    res = 8'd36;
      3'd2:    res = 8'd72;
      3'd3:    res = 8'd109;
      3'd4:    res = 8'd145;
      3'd5:    res = 8'd182;
      3'd6:    res = 8'd218;
      3'd7:    res = 8'd255;
      default: res = 8'd0;
    endcase
    return res;
  endfunction

  // floor(v * 255 / 15) is exactly v * 17: replicate the nibble
  function automatic logic [7:0] widen4(input logic [3:0] v);
    return {v, v};
  endfunction

  // floor(v * 255 / 31)
  function automatic logic [7:0] widen5(input logic [4:0] v);
    logic [7:0] res;
    case (v)
      5'd0:    res = 8'd0;
      5'd1:    res = 8'd8;
      5'd2:    res = 8'd16;
      5'd3:    res = 8'd24;
      5'd4:    res = 8'd32;
      5'd5:    res = 8'd41;
      5'd6:    res = 8'd49;
      5'd7:    res = 8'd57;
      5'd8:    res = 8'd65;
      5'd9:    res = 8'd74;
      5'd10:   res = 8'd82;
      5'd11:   res = 8'd90;
      5'd12:   res = 8'd98;
      5'd13:   res = 8'd106;
      5'd14:   res = 8'd115;
      5'd15:   res = 8'd123;
      5'd16:   res = 8'd131;
      5'd17:   res = 8'd139;
      5'd18:   res = 8'd148;
      5'd19:   res = 8'd156;
      5'd20:   res = 8'd164;
      5'd21:   res = 8'd172;
      5'd22:   res = 8'd180;
      5'd23:   res = 8'd189;
      5'd24:   res = 8'd197;
      5'd25:   res = 8'd205;
      5'd26:   res = 8'd213;
      5'd27:   res = 8'd222;
      5'd28:   res = 8'd230;
      5'd29:   res = 8'd238;
      5'd30:   res = 8'd246;
      5'd31:   res = 8'd255;
      default: res = 8'd0;
    endcase
    return res;
  endfunction

endpackage

/* rtl/rgb5a3_tile_decoder_core.sv */
// ============================================================================
// rgb5a3_tile_decoder_core - RGB5A3 tiled texture to ARGB8888 decoder
// Walks 4x4 tiles of 16-bit texels and emits byte offset plus ARGB pixel.
// ============================================================================
// Usage:
//   in_*  : one 16-bit texel per beat, tiles row-major, texels row-major in
//           each tile. First stored byte sits in in_tdata[15:8].
//   out_* : one beat per texel: destination byte offset (row*pitch + col*4,
//           mod 2^24) and the ARGB8888 pixel; out_tlast marks the final
//           texel of the image, after which the walk restarts at tile 0.
//   cfg_* : width, height (pixels, multiples of four) and row pitch; write
//           only while no texel is in flight.
// Timing: one texel per cycle sustained while the sink takes every beat. A texel
//   on its way out passes the queue, the multiply stage and the output register.
//   The row*pitch product gets its own stage ahead of the offset add.
// Stall: the two-entry queue plus two registered stages absorb a stalled
//   sink; in_tready drops only when the queue is full.
// Reset: position returns to tile 0, texel 0; width=4, height=4, pitch=16;
//   the pipeline empties.
// ============================================================================
module rgb5a3_tile_decoder_core #(
  parameter int MAX_DIM = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  // input texel beats
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] texel_word
  // decoded pixel beats
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata,   // [23:0] byte_offset, [55:24] argb
  output logic        out_tlast,   // last_pixel
  // configuration writes
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_wdata
);
  import rtdec_pkg::*;

  localparam int LIM = (MAX_DIM / 4 > 0) ? MAX_DIM / 4 : 1;
  localparam int TW  = (LIM > 1) ? $clog2(LIM) : 1;
  localparam int QW  = $bits(rtdec_ctl_t) + TEXEL_W + 2 * (TW + 2);

  logic [DIM_W-1:0]   width_px_r, width_px_nxt;
  logic [DIM_W-1:0]   height_px_r, height_px_nxt;
  logic [PITCH_W-1:0] row_pitch_r, row_pitch_nxt;

  logic               push, q_full, q_valid, q_pop;
  rtdec_ctl_t         push_ctl, q_ctl;
  logic [TEXEL_W-1:0] push_word, q_word;
  logic [TW+1:0]      push_row, push_col, q_row, q_col;
  logic [QW-1:0]      q_in, q_out;
  logic [OFFS_W-1:0]  byte_offset;
  logic [ARGB_W-1:0]  argb;

  // Configuration registers; unknown index is ignored
  always_comb begin
    width_px_nxt  = width_px_r;
    height_px_nxt = height_px_r;
    row_pitch_nxt = row_pitch_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_WIDTH_PX:  width_px_nxt  = cfg_wdata[DIM_W-1:0];
        CFG_HEIGHT_PX: height_px_nxt = cfg_wdata[DIM_W-1:0];
        CFG_ROW_PITCH: row_pitch_nxt = cfg_wdata;
        default:       ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_px_r  <= WIDTH_RST;
      height_px_r <= HEIGHT_RST;
      row_pitch_r <= PITCH_RST;
    end else begin
      width_px_r  <= width_px_nxt;
      height_px_r <= height_px_nxt;
      row_pitch_r <= row_pitch_nxt;
    end
  end

  rtdec_front #(
    .MAX_DIM (MAX_DIM),
    .LIM     (LIM),
    .TW      (TW)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .width_px  (width_px_r),
    .height_px (height_px_r),
    .push      (push),
    .push_ctl  (push_ctl),
    .push_word (push_word),
    .push_row  (push_row),
    .push_col  (push_col),
    .q_full    (q_full)
  );

  assign q_in = {push_ctl, push_word, push_row, push_col};
  assign {q_ctl, q_word, q_row, q_col} = q_out;

  rtdec_queue #(
    .DW (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .pop_data  (q_out)
  );

  rtdec_back #(
    .TW (TW)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .q_ctl       (q_ctl),
    .q_word      (q_word),
    .q_row       (q_row),
    .q_col       (q_col),
    .row_pitch   (row_pitch_r),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .byte_offset (byte_offset),
    .argb        (argb),
    .last_pixel  (out_tlast)
  );

  assign out_tdata = {argb, byte_offset};

endmodule

/* rtl/rtdec_front.sv */
// ============================================================================
// rtdec_front - texel intake and tile walker
// Accepts texel beats, tracks tile and in-tile position, tags each texel
// with its row, column, format and end-of-image flag and pushes it on.
// ============================================================================
module rtdec_front #(
  parameter int MAX_DIM = 1024,
  parameter int LIM     = (MAX_DIM / 4 > 0) ? MAX_DIM / 4 : 1,
  parameter int TW      = (LIM > 1) ? $clog2(LIM) : 1
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [rtdec_pkg::TEXEL_W-1:0]       in_tdata,
  input  logic [rtdec_pkg::DIM_W-1:0]         width_px,
  input  logic [rtdec_pkg::DIM_W-1:0]         height_px,
  output logic                                push,
  output rtdec_pkg::rtdec_ctl_t               push_ctl,
  output logic [rtdec_pkg::TEXEL_W-1:0]       push_word,
  output logic [TW+1:0]                       push_row,
  output logic [TW+1:0]                       push_col,
  input  logic                                q_full
);
  import rtdec_pkg::*;

  localparam int CW = $clog2(LIM + 1);

  logic [TW-1:0] tile_col_r, tile_col_nxt;
  logic [TW-1:0] tile_row_r, tile_row_nxt;
  logic [1:0]    sub_x_r, sub_x_nxt;
  logic [1:0]    sub_y_r, sub_y_nxt;
  logic [CW-1:0] tiles_x, tiles_y;
  logic          row_end, img_end, accept;

  // Tile counts: size/4 clamped to 1..LIM
  function automatic logic [CW-1:0] tiles_of(input logic [DIM_W-1:0] px);
    logic [DIM_W-3:0] t;
    logic [CW-1:0]    res;
    t = px[DIM_W-1:2];
    if (t == '0) begin
      res = CW'(1);
    end else if (int'(t) > LIM) begin
      res = CW'(LIM);
    end else begin
      res = CW'(t);
    end
    return res;
  endfunction

  assign tiles_x = tiles_of(width_px);
  assign tiles_y = tiles_of(height_px);

  assign row_end = ((CW+1)'(tile_col_r) + (CW+1)'(1)) >= (CW+1)'(tiles_x);
  assign img_end = ((CW+1)'(tile_row_r) + (CW+1)'(1)) >= (CW+1)'(tiles_y);

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;

  // Tag the texel
  assign push            = accept;
  assign push_word       = in_tdata;
  assign push_row        = {tile_row_r, sub_y_r};
  assign push_col        = {tile_col_r, sub_x_r};
  assign push_ctl.opaque = in_tdata[TEXEL_W-1];
  assign push_ctl.last   = (sub_x_r == 2'd3) && (sub_y_r == 2'd3) && row_end && img_end;

  // Position walk: x in tile, y in tile, tile column, tile row
  always_comb begin
    tile_col_nxt = tile_col_r;
    tile_row_nxt = tile_row_r;
    sub_x_nxt    = sub_x_r;
    sub_y_nxt    = sub_y_r;
    if (accept) begin
      sub_x_nxt = sub_x_r + 2'd1;
      if (sub_x_r == 2'd3) begin
        sub_y_nxt = sub_y_r + 2'd1;
        if (sub_y_r == 2'd3) begin
          if (!row_end) begin
            tile_col_nxt = tile_col_r + TW'(1);
          end else begin
            tile_col_nxt = '0;
            tile_row_nxt = img_end ? '0 : tile_row_r + TW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_col_r <= '0;
      tile_row_r <= '0;
      sub_x_r    <= '0;
      sub_y_r    <= '0;
    end else begin
      tile_col_r <= tile_col_nxt;
      tile_row_r <= tile_row_nxt;
      sub_x_r    <= sub_x_nxt;
      sub_y_r    <= sub_y_nxt;
    end
  end

endmodule

/* rtl/rtdec_queue.sv */
// ============================================================================
// rtdec_queue - two-entry queue between front and back end
// Register-based FIFO; push and pop may happen in the same cycle.
// ============================================================================
module rtdec_queue #(
  parameter int DW = 40
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output logic [DW-1:0] pop_data
);
  import rtdec_pkg::*;

  logic [DW-1:0] mem_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full     = (count_r == 2'd2);
  assign valid    = (count_r != 2'd0);
  assign pop_data = mem_r[rd_ptr_r];

  // Pointer and fill tracking
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && full && !pop))
    else $error("queue push while full");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && !valid))
    else $error("queue pop while empty");
  a_ptr_full: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd2 || count_r == 2'd0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree with fill count");
  a_ptr_one: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == 2'd1) |-> (wr_ptr_r != rd_ptr_r))
    else $error("queue pointers disagree with single entry");

endmodule

/* rtl/rtdec_back.sv */
// ============================================================================
// rtdec_back - offset arithmetic and color expansion
// Stage 1 multiplies row by pitch and widens the channels; stage 2 adds the
// column term and holds the output beat until the sink takes it.
// ============================================================================
module rtdec_back #(
  parameter int TW = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  rtdec_pkg::rtdec_ctl_t             q_ctl,
  input  logic [rtdec_pkg::TEXEL_W-1:0]     q_word,
  input  logic [TW+1:0]                     q_row,
  input  logic [TW+1:0]                     q_col,
  input  logic [rtdec_pkg::PITCH_W-1:0]     row_pitch,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [rtdec_pkg::OFFS_W-1:0]      byte_offset,
  output logic [rtdec_pkg::ARGB_W-1:0]      argb,
  output logic                              last_pixel
);
  import rtdec_pkg::*;

  localparam int PW = TW + 2 + PITCH_W;

  logic                s1_vld_r, s1_vld_nxt;
  logic [PW-1:0]       s1_prod_r;
  logic [TW+1:0]       s1_col_r;
  logic [ARGB_W-1:0]   s1_argb_r;
  logic                s1_last_r;
  logic                s2_vld_r, s2_vld_nxt;
  logic [OFFS_W-1:0]   s2_offs_r;
  logic [ARGB_W-1:0]   s2_argb_r;
  logic                s2_last_r;
  logic                s1_ready, s2_ready;
  logic [ARGB_W-1:0]   argb_dec;
  logic [PW:0]         offs_sum;

  // Stage handshakes
  assign s2_ready   = !s2_vld_r || out_tready;
  assign s1_ready   = !s1_vld_r || s2_ready;
  assign q_pop      = q_valid && s1_ready;
  assign s1_vld_nxt = s1_ready ? q_valid : s1_vld_r;
  assign s2_vld_nxt = s2_ready ? s1_vld_r : s2_vld_r;

  // Channel widening
  always_comb begin
    if (!q_ctl.opaque) begin
      argb_dec = {widen3(q_word[14:12]), widen4(q_word[11:8]),
                  widen4(q_word[7:4]), widen4(q_word[3:0])};
    end else begin
      argb_dec = {ALPHA_OPAQUE, widen5(q_word[14:10]),
                  widen5(q_word[9:5]), widen5(q_word[4:0])};
    end
  end

  // Column term is col*4; offset wraps at 24 bits
  assign offs_sum = (PW+1)'(s1_prod_r) + (PW+1)'({s1_col_r, 2'b00});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
      s2_vld_r <= s2_vld_nxt;
    end
  end

  // Stage 1 payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_prod_r <= PW'(q_row) * PW'(row_pitch);
      s1_col_r  <= q_col;
      s1_argb_r <= argb_dec;
      s1_last_r <= q_ctl.last;
    end
  end

  // Stage 2 payload (output register)
  always_ff @(posedge clk) begin
    if (s1_vld_r && s2_ready) begin
      s2_offs_r <= OFFS_W'(offs_sum);
      s2_argb_r <= s1_argb_r;
      s2_last_r <= s1_last_r;
    end
  end

  assign out_tvalid  = s2_vld_r;
  assign byte_offset = s2_offs_r;
  assign argb        = s2_argb_r;
  assign last_pixel  = s2_last_r;

endmodule
